### sv/counter_priority_scheduler_unit_assert.svh
// Assertion macros for the counter priority scheduler.
`ifndef COUNTER_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH
`define COUNTER_PRIORITY_SCHEDULER_UNIT_ASSERT_SVH

// Checked at every clock edge except while reset is applied.
`define CPS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define CPS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/cps_pkg.sv
// Shared types and constants of the counter priority scheduler.
`default_nettype none

package cps_pkg;

  localparam int MAX_TASKS_DEF  = 16;
  localparam int SLICE_BITS_DEF = 8;

  localparam int PRIO_W      = 8;
  localparam int TASK_OUT_W  = 4;
  localparam int SLICE_OUT_W = 8;

  localparam int UPC_W = 5;

  // program entry points
  localparam logic [UPC_W-1:0] UPC_TICK = 5'd0;
  localparam logic [UPC_W-1:0] UPC_ADD  = 5'd15;

  typedef enum logic [1:0] {
    ADDR_RUN = 2'd0,
    ADDR_IDX = 2'd1,
    ADDR_CNT = 2'd2
  } addr_sel_t;

  typedef enum logic [1:0] {
    CWR_NONE = 2'd0,
    CWR_ZERO = 2'd1,
    CWR_DEC  = 2'd2,
    CWR_PRIO = 2'd3
  } cnt_wr_t;

  typedef enum logic [1:0] {
    IDX_HOLD = 2'd0,
    IDX_ONE  = 2'd1,
    IDX_INC  = 2'd2
  } idx_op_t;

  typedef enum logic [1:0] {
    BEST_HOLD  = 2'd0,
    BEST_CLEAR = 2'd1,
    BEST_CMP   = 2'd2
  } best_op_t;

  typedef enum logic [2:0] {
    RES_NONE  = 3'd0,
    RES_KEEP  = 3'd1,
    RES_ADD   = 3'd2,
    RES_FULL  = 3'd3,
    RES_SCHED = 3'd4
  } res_op_t;

  typedef enum logic [2:0] {
    J_NONE    = 3'd0,
    J_ALWAYS  = 3'd1,
    J_RD_ZERO = 3'd2,
    J_RD_ONE  = 3'd3,
    J_IDX_GE  = 3'd4,
    J_BEST_NZ = 3'd5,
    J_FULL    = 3'd6
  } jmp_t;

  typedef struct packed {
    addr_sel_t        addr;
    logic             cnt_rd;
    logic             prio_rd;
    cnt_wr_t          cnt_wr;
    logic             prio_wr;
    logic             count_inc;
    idx_op_t          idx_op;
    best_op_t         best_op;
    res_op_t          res;
    jmp_t             jmp;
    logic [UPC_W-1:0] target;
    logic             last;
  } ctrl_t;

  typedef struct packed {
    logic rd_zero;
    logic rd_one;
    logic idx_ge;
    logic best_nz;
    logic full;
  } stat_t;

endpackage

`default_nettype wire

### sv/counter_priority_scheduler_unit.sv
// Top level of the counter priority scheduler: sequencer plus datapath.
// Programs: add task; tick without reschedule; tick picked on the first pass; tick with reload.
// A tick on which the running counter runs out also takes the decrement step before the pick.
// Throughput: one item at a time; busy drops as done rises, so the next item may enter
// at the edge that takes the result. The receiver cannot stall.
// Sync reset: one task (idle) in table, idle running, no result pending.
`default_nettype none
`include "counter_priority_scheduler_unit_assert.svh"

module counter_priority_scheduler_unit #(
  parameter int MAX_TASKS  = cps_pkg::MAX_TASKS_DEF,
  parameter int SLICE_BITS = cps_pkg::SLICE_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic                              cmd,
  input  wire logic [cps_pkg::PRIO_W-1:0]        new_priority,
  output logic                                   done,
  output logic [cps_pkg::TASK_OUT_W-1:0]         running_task,
  output logic [cps_pkg::SLICE_OUT_W-1:0]        remaining_slice,
  output logic                                   switched,
  output logic [cps_pkg::TASK_OUT_W-1:0]         added_task,
  output logic                                   table_full
);
  import cps_pkg::*;

  // An item enters when start is seen while the program is not running.
  logic  accept;
  ctrl_t ctrl;
  stat_t stat;

  assign accept = start && !busy;

  // Sequencer walks the microcode; the control word is gated to a no-op
  // whenever no program is running.
  cps_sequencer u_seq (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cmd    (cmd),
    .stat   (stat),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  // Datapath holds the counter and priority tables. Counters of slots past
  // the fill count are never used, and the idle slot reads as zero, so the
  // counter table needs no clearing pass after reset.
  cps_datapath #(
    .MAX_TASKS  (MAX_TASKS),
    .SLICE_BITS (SLICE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .accept          (accept),
    .new_priority    (new_priority),
    .ctrl            (ctrl),
    .stat            (stat),
    .done            (done),
    .running_task    (running_task),
    .remaining_slice (remaining_slice),
    .switched        (switched),
    .added_task      (added_task),
    .table_full      (table_full)
  );

  // Accepted item starts the program.
  `CPS_ASSERT(a_accept_busy, accept |=> busy, "accepted item did not start the program")
  // A result comes only after the program has ended.
  `CPS_ASSERT(a_done_idle, done |-> !busy, "result strobed while program still running")
  // Switch only on a tick, never together with add results.
  `CPS_ASSERT(a_switch_tick, (done && switched) |-> (!table_full && (added_task == '0)), "switch reported on an add item")
  // Reset leaves nothing running and nothing pending.
  `CPS_ASSERT_ALWAYS(a_reset_clear, $past(rst) |-> (!busy && !done), "sequencer not idle after reset")

endmodule

`default_nettype wire

### sv/cps_ucode_rom.sv
// Microcode ROM: one control word per program step.
`default_nettype none

module cps_ucode_rom (
  input  wire logic [cps_pkg::UPC_W-1:0] upc,
  output cps_pkg::ctrl_t                 word
);
  import cps_pkg::*;

  // tick: fetch running counter, decrement
  localparam logic [UPC_W-1:0] T_RD    = 5'd0;
  localparam logic [UPC_W-1:0] T_CHK   = 5'd1;
  localparam logic [UPC_W-1:0] T_DEC   = 5'd2;
  localparam logic [UPC_W-1:0] T_KEEP  = 5'd3;
  // first pick pass
  localparam logic [UPC_W-1:0] P1_INIT = 5'd4;
  localparam logic [UPC_W-1:0] P1_TEST = 5'd5;
  localparam logic [UPC_W-1:0] P1_CMP  = 5'd6;
  localparam logic [UPC_W-1:0] P1_END  = 5'd7;
  // reload pass
  localparam logic [UPC_W-1:0] R_INIT  = 5'd8;
  localparam logic [UPC_W-1:0] R_TEST  = 5'd9;
  localparam logic [UPC_W-1:0] R_WR    = 5'd10;
  // second pick pass
  localparam logic [UPC_W-1:0] P2_INIT = 5'd11;
  localparam logic [UPC_W-1:0] P2_TEST = 5'd12;
  localparam logic [UPC_W-1:0] P2_CMP  = 5'd13;
  localparam logic [UPC_W-1:0] COMMIT  = 5'd14;
  // add task
  localparam logic [UPC_W-1:0] A_RD    = 5'd15;
  localparam logic [UPC_W-1:0] A_WR    = 5'd16;
  localparam logic [UPC_W-1:0] A_FULL  = 5'd17;

  always_comb begin
    word = '0;
    unique case (upc)
      T_RD: begin
        word.addr   = ADDR_RUN;
        word.cnt_rd = 1'b1;
      end
      T_CHK: begin
        word.jmp    = J_RD_ZERO;
        word.target = P1_INIT;
      end
      T_DEC: begin
        word.addr   = ADDR_RUN;
        word.cnt_wr = CWR_DEC;
        word.jmp    = J_RD_ONE;
        word.target = P1_INIT;
      end
      T_KEEP: begin
        word.res  = RES_KEEP;
        word.last = 1'b1;
      end
      P1_INIT: begin
        word.idx_op  = IDX_ONE;
        word.best_op = BEST_CLEAR;
      end
      P1_TEST: begin
        word.addr   = ADDR_IDX;
        word.cnt_rd = 1'b1;
        word.jmp    = J_IDX_GE;
        word.target = P1_END;
      end
      P1_CMP: begin
        word.best_op = BEST_CMP;
        word.idx_op  = IDX_INC;
        word.jmp     = J_ALWAYS;
        word.target  = P1_TEST;
      end
      P1_END: begin
        word.jmp    = J_BEST_NZ;
        word.target = COMMIT;
      end
      R_INIT: begin
        word.idx_op = IDX_ONE;
      end
      R_TEST: begin
        word.addr    = ADDR_IDX;
        word.prio_rd = 1'b1;
        word.jmp     = J_IDX_GE;
        word.target  = P2_INIT;
      end
      R_WR: begin
        word.addr   = ADDR_IDX;
        word.cnt_wr = CWR_PRIO;
        word.idx_op = IDX_INC;
        word.jmp    = J_ALWAYS;
        word.target = R_TEST;
      end
      P2_INIT: begin
        word.idx_op  = IDX_ONE;
        word.best_op = BEST_CLEAR;
      end
      P2_TEST: begin
        word.addr   = ADDR_IDX;
        word.cnt_rd = 1'b1;
        word.jmp    = J_IDX_GE;
        word.target = COMMIT;
      end
      P2_CMP: begin
        word.best_op = BEST_CMP;
        word.idx_op  = IDX_INC;
        word.jmp     = J_ALWAYS;
        word.target  = P2_TEST;
      end
      COMMIT: begin
        word.res  = RES_SCHED;
        word.last = 1'b1;
      end
      A_RD: begin
        word.addr   = ADDR_RUN;
        word.cnt_rd = 1'b1;
        word.jmp    = J_FULL;
        word.target = A_FULL;
      end
      A_WR: begin
        word.addr      = ADDR_CNT;
        word.cnt_wr    = CWR_ZERO;
        word.prio_wr   = 1'b1;
        word.count_inc = 1'b1;
        word.res       = RES_ADD;
        word.last      = 1'b1;
      end
      A_FULL: begin
        word.res  = RES_FULL;
        word.last = 1'b1;
      end
      default: begin
        // unused step: end the program
        word.last = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/cps_datapath.sv
// Datapath: task tables, scan registers and result registers.
`default_nettype none

module cps_datapath #(
  parameter int MAX_TASKS  = cps_pkg::MAX_TASKS_DEF,
  parameter int SLICE_BITS = cps_pkg::SLICE_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           accept,
  input  wire logic [cps_pkg::PRIO_W-1:0]     new_priority,
  input  wire cps_pkg::ctrl_t                 ctrl,
  output cps_pkg::stat_t                      stat,
  output logic                                done,
  output logic [cps_pkg::TASK_OUT_W-1:0]      running_task,
  output logic [cps_pkg::SLICE_OUT_W-1:0]     remaining_slice,
  output logic                                switched,
  output logic [cps_pkg::TASK_OUT_W-1:0]      added_task,
  output logic                                table_full
);
  import cps_pkg::*;

  localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W = $clog2(MAX_TASKS + 1);

  logic [SLICE_BITS-1:0] cnt_mem  [MAX_TASKS];
  logic [PRIO_W-1:0]     prio_mem [MAX_TASKS];

  logic [PRIO_W-1:0]     prio_in;
  logic [CNT_W-1:0]      count;
  logic [IDX_W-1:0]      run;
  logic [CNT_W-1:0]      idx;
  logic [IDX_W-1:0]      best;
  logic [SLICE_BITS-1:0] best_cnt;
  logic [SLICE_BITS-1:0] cnt_q;
  logic                  cnt_q_idle;
  logic [PRIO_W-1:0]     prio_q;

  logic [IDX_W-1:0]      addr;
  logic [SLICE_BITS-1:0] rd_data;
  logic [SLICE_BITS-1:0] dec_data;
  logic [SLICE_BITS-1:0] cnt_wdata;

  always_comb begin
    unique case (ctrl.addr)
      ADDR_RUN: addr = run;
      ADDR_IDX: addr = idx[IDX_W-1:0];
      ADDR_CNT: addr = count[IDX_W-1:0];
      default:  addr = run;
    endcase
  end

  // idle slot always reads as zero; used user slots were written on add
  assign rd_data  = cnt_q_idle ? '0 : cnt_q;
  assign dec_data = rd_data - SLICE_BITS'(1);

  always_comb begin
    unique case (ctrl.cnt_wr)
      CWR_ZERO: cnt_wdata = '0;
      CWR_DEC:  cnt_wdata = dec_data;
      CWR_PRIO: cnt_wdata = SLICE_BITS'(prio_q);
      default:  cnt_wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.cnt_wr != CWR_NONE) begin
      cnt_mem[addr] <= cnt_wdata;
    end
    if (ctrl.cnt_rd) begin
      cnt_q      <= cnt_mem[addr];
      cnt_q_idle <= (addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.prio_wr) begin
      prio_mem[addr] <= prio_in;
    end
    if (ctrl.prio_rd) begin
      prio_q <= prio_mem[addr];
    end
  end

  always_comb begin
    stat.rd_zero = (rd_data == '0);
    stat.rd_one  = (rd_data == SLICE_BITS'(1));
    stat.idx_ge  = (idx >= count);
    stat.best_nz = (best_cnt != '0);
    stat.full    = (count >= CNT_W'(MAX_TASKS));
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      prio_in <= new_priority;
    end
    unique case (ctrl.idx_op)
      IDX_ONE:  idx <= CNT_W'(1);
      IDX_INC:  idx <= idx + CNT_W'(1);
      default:  idx <= idx;
    endcase
    unique case (ctrl.best_op)
      BEST_CLEAR: begin
        best     <= '0;
        best_cnt <= '0;
      end
      BEST_CMP: begin
        // strict compare: lowest index keeps ties
        if (rd_data > best_cnt) begin
          best     <= idx[IDX_W-1:0];
          best_cnt <= rd_data;
        end
      end
      default: begin
        best     <= best;
        best_cnt <= best_cnt;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CNT_W'(1);
      run   <= '0;
      done  <= 1'b0;
    end else begin
      if (ctrl.count_inc) begin
        count <= count + CNT_W'(1);
      end
      if (ctrl.res == RES_SCHED) begin
        run <= best;
      end
      done <= (ctrl.res != RES_NONE);
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctrl.res)
      RES_KEEP: begin
        running_task    <= TASK_OUT_W'(run);
        remaining_slice <= SLICE_OUT_W'(dec_data);
        switched        <= 1'b0;
        added_task      <= '0;
        table_full      <= 1'b0;
      end
      RES_ADD: begin
        running_task    <= TASK_OUT_W'(run);
        remaining_slice <= SLICE_OUT_W'(rd_data);
        switched        <= 1'b0;
        added_task      <= TASK_OUT_W'(count);
        table_full      <= 1'b0;
      end
      RES_FULL: begin
        running_task    <= TASK_OUT_W'(run);
        remaining_slice <= SLICE_OUT_W'(rd_data);
        switched        <= 1'b0;
        added_task      <= '0;
        table_full      <= 1'b1;
      end
      RES_SCHED: begin
        running_task    <= TASK_OUT_W'(best);
        remaining_slice <= SLICE_OUT_W'(best_cnt);
        switched        <= (best != run);
        added_task      <= '0;
        table_full      <= 1'b0;
      end
      default: begin
        running_task    <= running_task;
        remaining_slice <= remaining_slice;
        switched        <= switched;
        added_task      <= added_task;
        table_full      <= table_full;
      end
    endcase
  end

endmodule

`default_nettype wire

### sv/cps_sequencer.sv
// Sequencer: step counter, busy flag and conditional jumps over the ROM.
`default_nettype none

module cps_sequencer (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire logic  cmd,
  input  wire cps_pkg::stat_t stat,
  output cps_pkg::ctrl_t ctrl,
  output logic       busy
);
  import cps_pkg::*;

  logic [UPC_W-1:0] upc;
  logic [UPC_W-1:0] upc_next;
  logic             busy_next;
  ctrl_t            word;
  logic             take;

  cps_ucode_rom u_rom (
    .upc  (upc),
    .word (word)
  );

  // all-zero word is a no-op
  assign ctrl = busy ? word : '0;

  always_comb begin
    unique case (word.jmp)
      J_NONE:    take = 1'b0;
      J_ALWAYS:  take = 1'b1;
      J_RD_ZERO: take = stat.rd_zero;
      J_RD_ONE:  take = stat.rd_one;
      J_IDX_GE:  take = stat.idx_ge;
      J_BEST_NZ: take = stat.best_nz;
      J_FULL:    take = stat.full;
      default:   take = 1'b0;
    endcase
  end

  always_comb begin
    upc_next  = upc;
    busy_next = busy;
    if (accept) begin
      upc_next  = cmd ? UPC_ADD : UPC_TICK;
      busy_next = 1'b1;
    end else if (busy) begin
      upc_next  = take ? word.target : upc + UPC_W'(1);
      busy_next = !word.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc  <= UPC_TICK;
      busy <= 1'b0;
    end else begin
      upc  <= upc_next;
      busy <= busy_next;
    end
  end

endmodule

`default_nettype wire
